@@ rtl/core/spf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants and types for the smallest-prime-factor table factorizer.
// ----------------------------------------------------------------------------
package spf_pkg;

    // fixed field widths of the query and result ports
    localparam int QVAL_W = 12;
    localparam int EXP_W  = 4;

    // results per query never exceed this
    localparam int MAX_RESULTS = 5;

    // defaults for the top-level parameters
    localparam int DEF_MAX_VALUE   = 4095;
    localparam int DEF_PRIME_SLOTS = 564;

    // table port controls driven by the sieve sequencer
    typedef struct packed {
        logic we;
        logic re;
    } tbl_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/spf_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/core/spf_sieve.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spf_sieve
// Clears the factor table after reset, then builds it with the linear sieve,
// sequencing its table and prime-list accesses around a single multiplier.
// ----------------------------------------------------------------------------
module spf_sieve #(
    parameter int MAX_VALUE   = spf_pkg::DEF_MAX_VALUE,
    parameter int PRIME_SLOTS = spf_pkg::DEF_PRIME_SLOTS,
    localparam int VW = $clog2(MAX_VALUE + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    output logic                   table_ready,
    output spf_pkg::tbl_ctl_t      tbl_ctl,
    output logic      [VW-1:0]     tbl_waddr,
    output logic      [VW-1:0]     tbl_wdata,
    output logic      [VW-1:0]     tbl_raddr,
    input  wire logic [VW-1:0]     tbl_rdata
);

    import spf_pkg::*;

    localparam int CW  = $clog2(PRIME_SLOTS + 1);
    localparam int PAW = $clog2(PRIME_SLOTS);
    localparam int PW  = 2 * VW;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_RD_I  = 3'd1;
    localparam logic [2:0] S_CHK_I = 3'd2;
    localparam logic [2:0] S_RD_P  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [VW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic [VW-1:0] own_reg, own_next;
    logic [VW-1:0] p_reg, p_next;
    logic [PW-1:0] prod_reg, prod_next;

    logic           pl_we;
    logic [PAW-1:0] pl_waddr;
    logic [VW-1:0]  pl_wdata;
    logic           pl_re;
    logic [PAW-1:0] pl_raddr;
    logic [VW-1:0]  pl_rdata;
    logic           last_i;

    spf_ram #(
        .WIDTH (VW),
        .DEPTH (PRIME_SLOTS)
    ) u_prime_list (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .re    (pl_re),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    assign last_i = (i_reg == VW'(MAX_VALUE));

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        count_next = count_reg;
        own_next   = own_reg;
        p_next     = p_reg;
        prod_next  = prod_reg;
        tbl_ctl    = '0;
        tbl_waddr  = i_reg;
        tbl_wdata  = '0;
        tbl_raddr  = i_reg;
        pl_we      = 1'b0;
        pl_waddr   = count_reg[PAW-1:0];
        pl_wdata   = i_reg;
        pl_re      = 1'b0;
        pl_raddr   = k_reg[PAW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                tbl_ctl.we = 1'b1;
                if (last_i)
                begin
                    i_next     = VW'(2);
                    state_next = S_RD_I;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_RD_I:
            begin
                tbl_ctl.re = 1'b1;
                state_next = S_CHK_I;
            end
            S_CHK_I:
            begin
                k_next     = '0;
                state_next = S_RD_P;
                if (tbl_rdata == '0)
                begin
                    // unmarked: a new prime
                    tbl_ctl.we = 1'b1;
                    tbl_wdata  = i_reg;
                    own_next   = i_reg;
                    if (count_reg < CW'(PRIME_SLOTS))
                    begin
                        pl_we      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    own_next = tbl_rdata;
                end
            end
            S_RD_P:
            begin
                if (k_reg >= count_reg)
                begin
                    if (last_i)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RD_I;
                    end
                end
                else
                begin
                    pl_re      = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                p_next     = pl_rdata;
                prod_next  = {{VW{1'b0}}, i_reg} * {{VW{1'b0}}, pl_rdata};
                state_next = S_WR;
            end
            S_WR:
            begin
                if ((p_reg > own_reg) || (prod_reg > PW'(MAX_VALUE)))
                begin
                    if (last_i)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RD_I;
                    end
                end
                else
                begin
                    tbl_ctl.we = 1'b1;
                    tbl_waddr  = prod_reg[VW-1:0];
                    tbl_wdata  = p_reg;
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD_P;
                end
            end
            S_DONE:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            i_reg     <= '0;
            k_reg     <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        own_reg  <= own_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
    end

    assign table_ready = (state_reg == S_DONE);

endmodule
`default_nettype wire

@@ rtl/core/spf_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spf_divider
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module spf_divider #(
    parameter int W = 12
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic      [W-1:0] quotient,
    output logic      [W-1:0] remainder
);

    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            // no borrow means the trial subtraction fits
            rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
            quo_next = {quo_reg[W-2:0], ~diff[W]};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ rtl/core/spf_factor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spf_factor
// Query sequencer: looks up the smallest factor, divides it out repeatedly on
// its divider; one result per distinct prime, or one with no factor if out of range.
// ----------------------------------------------------------------------------
module spf_factor #(
    parameter int MAX_VALUE = spf_pkg::DEF_MAX_VALUE,
    localparam int VW = $clog2(MAX_VALUE + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        table_ready,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [spf_pkg::QVAL_W-1:0]  query_value,
    output logic                             tbl_re,
    output logic      [VW-1:0]               tbl_raddr,
    input  wire logic [VW-1:0]               tbl_rdata,
    output logic                             result_strobe,
    output logic      [spf_pkg::QVAL_W-1:0]  prime_factor,
    output logic      [spf_pkg::EXP_W-1:0]   exponent,
    output logic                             query_is_prime,
    output logic                             has_factor,
    output logic                             last
);

    import spf_pkg::*;

    localparam int NW = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_LOOK = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [NW-1:0]     n_reg, n_next;
    logic              dstart_reg, dstart_next;
    logic [VW-1:0]     x_reg, x_next;
    logic [VW-1:0]     p_reg, p_next;
    logic [EXP_W-1:0]  cnt_reg, cnt_next;
    logic              prime_reg, prime_next;

    logic              strobe_reg, strobe_next;
    logic [QVAL_W-1:0] pf_reg, pf_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic              isp_reg, isp_next;
    logic              hf_reg, hf_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              in_range;
    logic              factor_ok;
    logic              div_done;
    logic [VW-1:0]     div_quo;
    logic [VW-1:0]     div_rem;

    spf_divider #(
        .W (VW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dstart_reg),
        .dividend  (x_reg),
        .divisor   (p_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign accept    = start && table_ready && (state_reg == F_IDLE);
    assign in_range  = (query_value >= QVAL_W'(2)) && (32'(query_value) <= 32'(MAX_VALUE));
    assign factor_ok = (tbl_rdata >= VW'(2));

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        dstart_next = 1'b0;
        x_next      = x_reg;
        p_next      = p_reg;
        cnt_next    = cnt_reg;
        prime_next  = prime_reg;
        strobe_next = 1'b0;
        pf_next     = pf_reg;
        exp_next    = exp_reg;
        isp_next    = isp_reg;
        hf_next     = hf_reg;
        last_next   = last_reg;
        tbl_re      = 1'b0;
        tbl_raddr   = x_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (!in_range)
                    begin
                        strobe_next = 1'b1;
                        pf_next     = '0;
                        exp_next    = '0;
                        isp_next    = 1'b0;
                        hf_next     = 1'b0;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        x_next     = VW'(query_value);
                        n_next     = '0;
                        tbl_re     = 1'b1;
                        tbl_raddr  = VW'(query_value);
                        state_next = F_LOOK;
                    end
                end
            end
            F_LOOK:
            begin
                if (n_reg == '0)
                begin
                    prime_next = (tbl_rdata == x_reg);
                end
                else
                begin
                    // the previous prime is finished; this lookup decides its last mark
                    strobe_next = 1'b1;
                    pf_next     = QVAL_W'(p_reg);
                    exp_next    = cnt_reg;
                    isp_next    = prime_reg;
                    hf_next     = 1'b1;
                    last_next   = !factor_ok;
                end
                if (!factor_ok)
                begin
                    if (n_reg == '0)
                    begin
                        strobe_next = 1'b1;
                        pf_next     = '0;
                        exp_next    = '0;
                        isp_next    = (tbl_rdata == x_reg);
                        hf_next     = 1'b0;
                        last_next   = 1'b1;
                    end
                    state_next = F_IDLE;
                end
                else
                begin
                    p_next      = tbl_rdata;
                    cnt_next    = '0;
                    dstart_next = 1'b1;
                    state_next  = F_DIV;
                end
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        x_next      = div_quo;
                        cnt_next    = cnt_reg + 1'b1;
                        dstart_next = 1'b1;
                    end
                    else if ((x_reg < VW'(2)) || (n_reg == NW'(MAX_RESULTS - 1)))
                    begin
                        strobe_next = 1'b1;
                        pf_next     = QVAL_W'(p_reg);
                        exp_next    = cnt_reg;
                        isp_next    = prime_reg;
                        hf_next     = 1'b1;
                        last_next   = 1'b1;
                        state_next  = F_IDLE;
                    end
                    else
                    begin
                        n_next     = n_reg + 1'b1;
                        tbl_re     = 1'b1;
                        state_next = F_LOOK;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            n_reg      <= '0;
            dstart_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            dstart_reg <= dstart_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        p_reg     <= p_next;
        cnt_reg   <= cnt_next;
        prime_reg <= prime_next;
        pf_reg    <= pf_next;
        exp_reg   <= exp_next;
        isp_reg   <= isp_next;
        hf_reg    <= hf_next;
        last_reg  <= last_next;
    end

    assign busy           = !table_ready || (state_reg != F_IDLE);
    assign result_strobe  = strobe_reg;
    assign prime_factor   = pf_reg;
    assign exponent       = exp_reg;
    assign query_is_prime = isp_reg;
    assign has_factor     = hf_reg;
    assign last           = last_reg;

`ifndef SYNTH
    a_nofactor_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !hf_reg) |-> last_reg)
        else $error("result without factor not marked last");

    a_factor_at_least_two: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && hf_reg) |-> (pf_reg >= QVAL_W'(2)))
        else $error("emitted factor below two");

    a_div_start_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        dstart_reg |-> (state_reg == F_DIV))
        else $error("divider started outside division state");

    a_ready_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        table_ready |=> table_ready)
        else $error("table ready dropped");

    a_work_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != F_IDLE) |-> table_ready)
        else $error("query in flight before table built");
`endif

endmodule
`default_nettype wire

@@ rtl/core/spf_table_factorizer.sv @@
`default_nettype none
// after reset the table is cleared and then built by the linear sieve; busy stays
// high until then. a query below 2 or above MAX_VALUE answers in the next cycle;
// otherwise the query runs one trial division on its divider per prime power plus
// one per distinct prime, with a table lookup before each prime.
// one query at a time; results cannot be stalled. reset is asynchronous, active low.
// ----------------------------------------------------------------------------
// spf_table_factorizer
// Smallest-prime-factor table built by a linear sieve, and a query factorizer.
// ----------------------------------------------------------------------------
module spf_table_factorizer #(
    parameter int MAX_VALUE   = spf_pkg::DEF_MAX_VALUE,
    parameter int PRIME_SLOTS = spf_pkg::DEF_PRIME_SLOTS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [spf_pkg::QVAL_W-1:0]  query_value,
    output logic                             result_strobe,
    output logic      [spf_pkg::QVAL_W-1:0]  prime_factor,
    output logic      [spf_pkg::EXP_W-1:0]   exponent,
    output logic                             query_is_prime,
    output logic                             has_factor,
    output logic                             last
);

    import spf_pkg::*;

    localparam int VW = $clog2(MAX_VALUE + 1);

    tbl_ctl_t      sv_ctl;
    logic [VW-1:0] sv_waddr;
    logic [VW-1:0] sv_wdata;
    logic [VW-1:0] sv_raddr;
    logic          fac_re;
    logic [VW-1:0] fac_raddr;
    logic          table_ready;
    logic          tbl_re;
    logic [VW-1:0] tbl_raddr;
    logic [VW-1:0] tbl_rdata;

    // the sieve owns the table until it is built, the factorizer reads it after
    assign tbl_re    = table_ready ? fac_re : sv_ctl.re;
    assign tbl_raddr = table_ready ? fac_raddr : sv_raddr;

    spf_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VALUE + 1)
    ) u_factor_table (
        .clk   (clk),
        .we    (sv_ctl.we),
        .waddr (sv_waddr),
        .wdata (sv_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    spf_sieve #(
        .MAX_VALUE   (MAX_VALUE),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_sieve (
        .clk         (clk),
        .rst_n       (rst_n),
        .table_ready (table_ready),
        .tbl_ctl     (sv_ctl),
        .tbl_waddr   (sv_waddr),
        .tbl_wdata   (sv_wdata),
        .tbl_raddr   (sv_raddr),
        .tbl_rdata   (tbl_rdata)
    );

    spf_factor #(
        .MAX_VALUE (MAX_VALUE)
    ) u_factor (
        .clk            (clk),
        .rst_n          (rst_n),
        .table_ready    (table_ready),
        .start          (start),
        .busy           (busy),
        .query_value    (query_value),
        .tbl_re         (fac_re),
        .tbl_raddr      (fac_raddr),
        .tbl_rdata      (tbl_rdata),
        .result_strobe  (result_strobe),
        .prime_factor   (prime_factor),
        .exponent       (exponent),
        .query_is_prime (query_is_prime),
        .has_factor     (has_factor),
        .last           (last)
    );

endmodule
`default_nettype wire
